FILE: hw/rtl/proportional_glyph_tile_packer_core_assert.svh
// Assertion macros for the glyph tile packer.
// Included by the top level; compiles to nothing when SYNTH is defined.
`ifndef PROPORTIONAL_GLYPH_TILE_PACKER_CORE_ASSERT_SVH
`define PROPORTIONAL_GLYPH_TILE_PACKER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define PGTP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgtp same-cycle check failed");
// next-cycle implication
`define PGTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgtp next-cycle check failed");
`else
`define PGTP_ASSERT_NOW(label, clk, rst, ante, cons)
`define PGTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/pgtp_pkg.sv
// Shared types and constants of the glyph tile packer.
// No dependencies; used by all modules and the testbench.
`default_nettype none
package pgtp_pkg;

  localparam int unsigned PIX_W  = 4;
  localparam int unsigned ROW_W  = 32;
  localparam int unsigned COLS   = 8;
  localparam int unsigned SLOT_OUT_W = 5;

  // command codes
  localparam logic CMD_GLYPH = 1'b0;
  localparam logic CMD_PAD   = 1'b1;

  localparam logic [2:0] LAST_ROW = 3'd7;

  typedef struct packed {
    logic        command;
    logic [3:0]  glyph_width;
    logic [2:0]  row_number;
    logic [31:0] upper_glyph_row;
    logic [31:0] lower_glyph_row;
  } glyph_item_t;

  // control from the merge logic to the row store and output register
  typedef struct packed {
    logic       wr_en;
    logic       fill_en;
    logic [2:0] fill_next;
    logic       slot_inc;
    logic       slot_clr;
    logic       emit;
    logic       done;
  } store_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pgtp_channels.sv
// Valid/ready channel interfaces for glyph rows in and tile rows out.
// Depends on nothing; widths follow the pgtp_pkg item layout.
`default_nettype none
interface pgtp_glyph_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [3:0]  glyph_width;
  logic [2:0]  row_number;
  logic [31:0] upper_glyph_row;
  logic [31:0] lower_glyph_row;

  modport source (output valid, command, glyph_width, row_number,
                  upper_glyph_row, lower_glyph_row, input ready);
  modport sink   (input valid, command, glyph_width, row_number,
                  upper_glyph_row, lower_glyph_row, output ready);
endinterface

interface pgtp_tile_if;
  logic        valid;
  logic        ready;
  logic [4:0]  tile_slot;
  logic [2:0]  out_row_number;
  logic [31:0] upper_tile_row;
  logic [31:0] lower_tile_row;
  logic        string_done;

  modport source (output valid, tile_slot, out_row_number, upper_tile_row,
                  lower_tile_row, string_done, input ready);
  modport sink   (input valid, tile_slot, out_row_number, upper_tile_row,
                  lower_tile_row, string_done, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/proportional_glyph_tile_packer_core.sv
// An accepted transaction waits in the input register, is merged combinationally
// and, if it emits a tile row, loads the result register once free or draining.
// Throughput: one glyph row per cycle unless the tile side stalls; the row buffer
// read-modify-write sits between the input register and the result register.
// Reset (rst, synchronous): clears fill column, tile slot and both valid flags;
// row buffers hold undefined data until written.
`default_nettype none
module proportional_glyph_tile_packer_core #(
  parameter int unsigned MAX_TILES = 32
) (
  input  logic  clk,
  input  logic  rst,
  pgtp_glyph_if.sink  glyph,
  pgtp_tile_if.source tile
);
  import pgtp_pkg::*;

  localparam int unsigned SLOT_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  logic                in_valid;
  glyph_item_t         item;
  logic                step;
  store_ctl_t          ctl;
  logic [31:0]         wr_upper, wr_lower;
  logic [31:0]         rd_upper, rd_lower;
  logic [31:0]         res_upper, res_lower;
  logic [2:0]          fill;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W+4:0]   slot_ext;

  logic                out_valid;
  logic [4:0]          out_slot;
  logic [2:0]          out_row;
  logic [31:0]         out_upper, out_lower;
  logic                out_done;

  // the held item advances when the result register is free or draining
  assign step        = in_valid && (!out_valid || tile.ready);
  assign glyph.ready = !in_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (glyph.ready) begin
      in_valid <= glyph.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (glyph.ready && glyph.valid) begin
      item.command         <= glyph.command;
      item.glyph_width     <= glyph.glyph_width;
      item.row_number      <= glyph.row_number;
      item.upper_glyph_row <= glyph.upper_glyph_row;
      item.lower_glyph_row <= glyph.lower_glyph_row;
    end
  end

  pgtp_merge u_merge (
    .item      (item),
    .fill      (fill),
    .buf_upper (rd_upper),
    .buf_lower (rd_lower),
    .ctl       (ctl),
    .wr_upper  (wr_upper),
    .wr_lower  (wr_lower),
    .res_upper (res_upper),
    .res_lower (res_lower)
  );

  pgtp_row_store #(
    .MAX_TILES (MAX_TILES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .row      (item.row_number),
    .ctl      (ctl),
    .wr_upper (wr_upper),
    .wr_lower (wr_lower),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower),
    .fill     (fill),
    .slot     (slot)
  );

  assign slot_ext = {5'd0, slot};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && ctl.emit) begin
      out_valid <= 1'b1;
    end else if (tile.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ctl.emit) begin
      out_slot  <= slot_ext[4:0];
      out_row   <= item.row_number;
      out_upper <= res_upper;
      out_lower <= res_lower;
      out_done  <= ctl.done;
    end
  end

  assign tile.valid          = out_valid;
  assign tile.tile_slot      = out_slot;
  assign tile.out_row_number = out_row;
  assign tile.upper_tile_row = out_upper;
  assign tile.lower_tile_row = out_lower;
  assign tile.string_done    = out_done;

  // checks
`include "proportional_glyph_tile_packer_core_assert.svh"

  `PGTP_ASSERT_NEXT(a_pad_end_clears, clk, rst,
    step && item.command == CMD_PAD && item.row_number == LAST_ROW,
    fill == 3'd0 && slot == '0)
  `PGTP_ASSERT_NEXT(a_emit_loads, clk, rst, step && ctl.emit, out_valid)
  `PGTP_ASSERT_NOW(a_done_last_row, clk, rst, out_valid && out_done,
    out_row == LAST_ROW)
  `PGTP_ASSERT_NOW(a_slot_range, clk, rst, 1'b1,
    32'(slot) < 32'(MAX_TILES))

endmodule
`default_nettype wire

FILE: hw/rtl/pgtp_merge.sv
// Combinational merge of one glyph or padding row into the tile row buffer.
// Depends on pgtp_pkg.
`default_nettype none
module pgtp_merge (
  input  pgtp_pkg::glyph_item_t item,
  input  logic [2:0]            fill,
  input  logic [31:0]           buf_upper,
  input  logic [31:0]           buf_lower,
  output pgtp_pkg::store_ctl_t  ctl,
  output logic [31:0]           wr_upper,
  output logic [31:0]           wr_lower,
  output logic [31:0]           res_upper,
  output logic [31:0]           res_lower
);
  import pgtp_pkg::*;

  logic [3:0]  w_eff;
  logic [31:0] mask;
  logic [31:0] mu, ml;
  logic [4:0]  sh;
  logic [4:0]  rs;
  logic [2:0]  inv_fill;
  logic [3:0]  total;
  logic [3:0]  ovf;
  logic [31:0] base_u, base_l;
  logic [31:0] merged_u, merged_l;
  logic        last;

  // width clamp and nibble mask
  always_comb begin
    w_eff = (item.glyph_width > 4'd8) ? 4'd8 : item.glyph_width;
    for (int i = 0; i < COLS; i++) begin
      mask[PIX_W*i +: PIX_W] = {PIX_W{(4'(i) < w_eff)}};
    end
  end

  assign mu       = item.upper_glyph_row & mask;
  assign ml       = item.lower_glyph_row & mask;
  assign sh       = {fill, 2'b00};
  assign inv_fill = 3'd0 - fill;          // 8 - fill for fill >= 1
  assign rs       = {inv_fill, 2'b00};
  assign total    = {1'b0, fill} + w_eff;
  assign ovf      = total - 4'd8;
  assign last     = (item.row_number == LAST_ROW);

  // a glyph row at column zero starts a fresh buffer row
  assign base_u = (fill == 3'd0) ? '0 : buf_upper;
  assign base_l = (fill == 3'd0) ? '0 : buf_lower;

  always_comb begin
    ctl       = '0;
    merged_u  = '0;
    merged_l  = '0;
    wr_upper  = '0;
    wr_lower  = '0;
    unique case (item.command)
      CMD_PAD: begin
        merged_u = buf_upper | (item.upper_glyph_row << sh);
        merged_l = buf_lower | (item.lower_glyph_row << sh);
        wr_upper = merged_u;
        wr_lower = merged_l;
        // empty tile: nothing to flush
        if (fill != 3'd0) begin
          ctl.wr_en = 1'b1;
          ctl.emit  = 1'b1;
          ctl.done  = last;
        end
        if (last) begin
          ctl.fill_en   = 1'b1;
          ctl.fill_next = 3'd0;
          ctl.slot_clr  = 1'b1;
        end
      end
      CMD_GLYPH: begin
        merged_u  = base_u | (mu << sh);
        merged_l  = base_l | (ml << sh);
        ctl.wr_en = 1'b1;
        if (total[3]) begin
          // tile edge reached: emit, carry overflow pixels over
          ctl.emit = 1'b1;
          wr_upper = (ovf[2:0] != 3'd0) ? (mu >> rs) : '0;
          wr_lower = (ovf[2:0] != 3'd0) ? (ml >> rs) : '0;
          if (last) begin
            ctl.fill_en   = 1'b1;
            ctl.fill_next = ovf[2:0];
            ctl.slot_inc  = 1'b1;
          end
        end else begin
          wr_upper = merged_u;
          wr_lower = merged_l;
          if (last) begin
            ctl.fill_en   = 1'b1;
            ctl.fill_next = total[2:0];
          end
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  assign res_upper = merged_u;
  assign res_lower = merged_l;

endmodule
`default_nettype wire

FILE: hw/rtl/pgtp_row_store.sv
// Row buffers of the tile under construction, fill column and tile slot.
// Depends on pgtp_pkg.
`default_nettype none
module pgtp_row_store #(
  parameter int unsigned MAX_TILES = 32,
  localparam int unsigned SLOT_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [2:0]           row,
  input  pgtp_pkg::store_ctl_t ctl,
  input  logic [31:0]          wr_upper,
  input  logic [31:0]          wr_lower,
  output logic [31:0]          rd_upper,
  output logic [31:0]          rd_lower,
  output logic [2:0]           fill,
  output logic [SLOT_W-1:0]    slot
);
  import pgtp_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_TILES - 1);

  logic [31:0] upper_buf [COLS];
  logic [31:0] lower_buf [COLS];

  // buffer rows, no reset (contents defined once written)
  always_ff @(posedge clk) begin
    if (step && ctl.wr_en) begin
      upper_buf[row] <= wr_upper;
      lower_buf[row] <= wr_lower;
    end
  end

  assign rd_upper = upper_buf[row];
  assign rd_lower = lower_buf[row];

  // fill column and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 3'd0;
      slot <= '0;
    end else if (step) begin
      if (ctl.fill_en) begin
        fill <= ctl.fill_next;
      end
      if (ctl.slot_clr) begin
        slot <= '0;
      end else if (ctl.slot_inc) begin
        slot <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/proportional_glyph_tile_packer_core_tb.sv
// Self-checking testbench for proportional_glyph_tile_packer_core.
// Uses pgtp_pkg and the pgtp_glyph_if / pgtp_tile_if channel interfaces from the RTL.
// A scoreboard class predicts the packed tile rows; tasks drive glyph rows with random gaps.
`default_nettype none
module proportional_glyph_tile_packer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pgtp_pkg::*;

  localparam int unsigned TILES       = 32;
  localparam int unsigned RANDOM_ROWS = 750;

  typedef struct packed {
    logic [4:0]  slot;
    logic [2:0]  row;
    logic [31:0] upper;
    logic [31:0] lower;
    logic        done;
  } tile_row_t;

  // Tracks packer state and the tile rows still owed by the block
  class tile_row_tracker;
    logic [31:0] upper_rows [8];
    logic [31:0] lower_rows [8];
    logic [2:0]  fill_col = 3'd0;
    int unsigned slot;
    tile_row_t   expected_tile_rows [$];
    int          errors;

    function int pending();
      return expected_tile_rows.size();
    endfunction

    function void emit(logic [2:0] row, logic [31:0] up, logic [31:0] lo, logic done);
      tile_row_t t;
      t.slot  = slot[4:0];
      t.row   = row;
      t.upper = up;
      t.lower = lo;
      t.done  = done;
      expected_tile_rows.push_back(t);
    endfunction

    // Merge one accepted glyph or padding row into the tile buffers
    function void absorb_glyph_row(glyph_item_t it);
      int unsigned w;
      int unsigned sh;
      int unsigned total;
      int unsigned ovf;
      logic [31:0] mask;
      logic [31:0] mu;
      logic [31:0] ml;
      logic [31:0] bu;
      logic [31:0] bl;
      sh = 4 * fill_col;
      if (it.command == CMD_PAD) begin
        if (fill_col != 0) begin
          upper_rows[it.row_number] = upper_rows[it.row_number] | (it.upper_glyph_row << sh);
          lower_rows[it.row_number] = lower_rows[it.row_number] | (it.lower_glyph_row << sh);
          emit(it.row_number, upper_rows[it.row_number], lower_rows[it.row_number],
               it.row_number == LAST_ROW);
        end
        if (it.row_number == LAST_ROW) begin
          fill_col = '0;
          slot     = 0;
        end
        return;
      end
      w    = (it.glyph_width > 8) ? 8 : it.glyph_width;
      mask = (w == 8) ? 32'hFFFF_FFFF : ((32'd1 << (4 * w)) - 32'd1);
      mu   = it.upper_glyph_row & mask;
      ml   = it.lower_glyph_row & mask;
      // at fill zero the row starts fresh
      bu   = (fill_col == 0) ? 32'd0 : upper_rows[it.row_number];
      bl   = (fill_col == 0) ? 32'd0 : lower_rows[it.row_number];
      bu   = bu | (mu << sh);
      bl   = bl | (ml << sh);
      total = fill_col + w;
      if (total >= 8) begin
        ovf = total - 8;
        emit(it.row_number, bu, bl, 1'b0);
        if (ovf != 0) begin
          bu = mu >> (4 * (8 - fill_col));
          bl = ml >> (4 * (8 - fill_col));
        end else begin
          bu = '0;
          bl = '0;
        end
        if (it.row_number == LAST_ROW) begin
          fill_col = ovf[2:0];
          slot     = (slot + 1) % TILES;
        end
      end else if (it.row_number == LAST_ROW) begin
        fill_col = total[2:0];
      end
      upper_rows[it.row_number] = bu;
      lower_rows[it.row_number] = bl;
    endfunction

    // Compare one accepted tile row against the oldest prediction
    function void check_tile_row(tile_row_t got);
      tile_row_t want;
      if (expected_tile_rows.size() == 0) begin
        $error("unexpected tile row: tile_slot %0d out_row_number %0d", got.slot, got.row);
        errors++;
        return;
      end
      want = expected_tile_rows.pop_front();
      if (got.slot !== want.slot) begin
        $error("tile_slot: expected %0d, actual %0d", want.slot, got.slot);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("out_row_number: expected %0d, actual %0d", want.row, got.row);
        errors++;
      end
      if (got.upper !== want.upper) begin
        $error("upper_tile_row: expected %h, actual %h", want.upper, got.upper);
        errors++;
      end
      if (got.lower !== want.lower) begin
        $error("lower_tile_row: expected %h, actual %h", want.lower, got.lower);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("string_done: expected %0d, actual %0d", want.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   rows_sent;
  tile_row_tracker sb;

  pgtp_glyph_if glyph ();
  pgtp_tile_if  tile ();

  proportional_glyph_tile_packer_core #(.MAX_TILES(TILES)) dut (
    .clk   (clk),
    .rst   (rst),
    .glyph (glyph),
    .tile  (tile)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("proportional_glyph_tile_packer_core verification failed");
    $finish;
  end

  // Mostly random pixels, now and then a blank or solid row
  function automatic logic [31:0] pixel_word();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // One transaction on the glyph channel, with random idle cycles ahead of it
  task automatic send_row(input logic cmd, input logic [3:0] w, input logic [2:0] row,
                          input logic [31:0] up, input logic [31:0] lo);
    glyph_item_t it;
    it = '{cmd, w, row, up, lo};
    while ($urandom_range(99) < send_idle_pct) begin
      glyph.valid <= 1'b0;
      @(posedge clk);
    end
    glyph.valid           <= 1'b1;
    glyph.command         <= cmd;
    glyph.glyph_width     <= w;
    glyph.row_number      <= row;
    glyph.upper_glyph_row <= up;
    glyph.lower_glyph_row <= lo;
    @(posedge clk);
    while (!glyph.ready) @(posedge clk);
    sb.absorb_glyph_row(it);
    rows_sent++;
  endtask

  task automatic send_glyph(input logic [3:0] w);
    for (int r = 0; r < 8; r++) send_row(CMD_GLYPH, w, 3'(r), pixel_word(), pixel_word());
  endtask

  task automatic send_padding();
    for (int r = 0; r < 8; r++)
      send_row(CMD_PAD, 4'($urandom_range(15)), 3'(r), pixel_word(), pixel_word());
  endtask

  // Sender goes idle until every predicted tile row has come out
  task automatic drain();
    glyph.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: check at each accepting edge, then pick the next ready
  initial begin
    tile.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tile.valid && tile.ready)
        sb.check_tile_row(tile_row_t'{tile.tile_slot, tile.out_row_number,
                                      tile.upper_tile_row, tile.lower_tile_row,
                                      tile.string_done});
      tile.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus
  initial begin
    int idle_pct  [4];
    int stall_pct [4];
    int phase;
    int next_phase;
    int nglyph;
    logic [3:0] w;

    idle_pct  = '{0, 68, 0, 27};
    stall_pct = '{0, 0, 68, 27};
    sb = new;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rows_sent      = 0;
    rst                   <= 1'b1;
    glyph.valid           <= 1'b0;
    glyph.command         <= CMD_GLYPH;
    glyph.glyph_width     <= '0;
    glyph.row_number      <= '0;
    glyph.upper_glyph_row <= '0;
    glyph.lower_glyph_row <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-width rows write buffer rows 0 to 6 first (exact tile fill)
    for (int r = 0; r < 7; r++)
      send_row(CMD_GLYPH, 4'd8, 3'(r), r[0] ? 32'hFFFF_FFFF : 32'd0,
               r[0] ? 32'd0 : 32'hFFFF_FFFF);
    // width above eight on the last row
    send_row(CMD_GLYPH, 4'd15, LAST_ROW, 32'd0, 32'hFFFF_FFFF);
    // end of string with nothing pending
    send_row(CMD_PAD, 4'd0, LAST_ROW, pixel_word(), pixel_word());
    // zero width leaves the fill column alone
    send_row(CMD_GLYPH, 4'd0, LAST_ROW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_row(CMD_GLYPH, 4'd5, LAST_ROW, pixel_word(), pixel_word());
    // overflow on a row other than the last, then on the last
    send_row(CMD_GLYPH, 4'd6, 3'd2, 32'hFFFF_FFFF, 32'h1234_5678);
    send_row(CMD_GLYPH, 4'd6, LAST_ROW, 32'h8765_4321, 32'hFFFF_FFFF);
    send_row(CMD_GLYPH, 4'd1, LAST_ROW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_padding();
    drain();

    // Random: idling profile changes every quarter, with a full drain between
    rows_sent = 0;
    phase     = 0;
    // one long string so the tile slot wraps
    for (int g = 0; g < 44; g++) send_glyph(4'($urandom_range(6, 15)));
    send_padding();
    while (rows_sent < RANDOM_ROWS) begin
      next_phase = rows_sent * 4 / RANDOM_ROWS;
      if (next_phase > 3) next_phase = 3;
      if (next_phase != phase) begin
        drain();
        phase          = next_phase;
        send_idle_pct  = idle_pct[phase];
        recv_stall_pct = stall_pct[phase];
      end
      if ($urandom_range(9) < 7) begin
        nglyph = $urandom_range(1, 5);
        for (int g = 0; g < nglyph; g++) begin
          w = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
          send_glyph(w);
        end
        if ($urandom_range(4) != 0) send_padding();
      end else begin
        // broken sequences: rows out of order, any width, either command
        nglyph = $urandom_range(1, 6);
        for (int i = 0; i < nglyph; i++)
          send_row(1'($urandom_range(1)), 4'($urandom_range(15)), 3'($urandom_range(7)),
                   pixel_word(), pixel_word());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("proportional_glyph_tile_packer_core verification clean");
    end else begin
      $display("proportional_glyph_tile_packer_core verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
